// File: sv/vpp_pkg.sv
// Shared types and constants for the view projection point pipeline.
// Used by vpp_root_step and view_projection_point_project; no dependencies.
package vpp_pkg;

   localparam int NUM_REGS    = 8;
   localparam int ROOT_STEPS  = 32;   // one result bit of the 64-bit square root per step
   localparam int RATIO_STEPS = 17;   // integer bit plus 16 fraction bits of |X|/W
   localparam int ROOT_TOP    = 62;   // position of the first trial bit of the root
   localparam int SCREEN_MULT = 1000;

   // Register indexes on the csr port
   localparam logic [2:0] REG_R0_C01 = 3'd0;
   localparam logic [2:0] REG_R0_C23 = 3'd1;
   localparam logic [2:0] REG_R1_C01 = 3'd2;
   localparam logic [2:0] REG_R1_C23 = 3'd3;
   localparam logic [2:0] REG_R2_C01 = 3'd4;
   localparam logic [2:0] REG_R2_C23 = 3'd5;
   localparam logic [2:0] REG_R3_C01 = 3'd6;
   localparam logic [2:0] REG_R3_C23 = 3'd7;

   // Identity matrix in Q16.16
   localparam logic [63:0] RST_R0_C01 = 64'h0000_0000_0001_0000;
   localparam logic [63:0] RST_R0_C23 = 64'h0;
   localparam logic [63:0] RST_R1_C01 = 64'h0001_0000_0000_0000;
   localparam logic [63:0] RST_R1_C23 = 64'h0;
   localparam logic [63:0] RST_R2_C01 = 64'h0;
   localparam logic [63:0] RST_R2_C23 = 64'h0000_0000_0001_0000;
   localparam logic [63:0] RST_R3_C01 = 64'h0;
   localparam logic [63:0] RST_R3_C23 = 64'h0001_0000_0000_0000;

   // State carried through the root / ratio steps
   typedef struct packed {
      logic [63:0] v0;      // column 0 root remainder
      logic [63:0] r0;      // column 0 root
      logic [63:0] v1;      // column 1 root remainder
      logic [63:0] r1;      // column 1 root
      logic [64:0] rem_x;   // |X| division remainder
      logic [64:0] rem_y;   // |Y| division remainder
      logic [63:0] den;     // W
      logic [16:0] q_x;     // |X|/W, Q.16
      logic [16:0] q_y;     // |Y|/W, Q.16
      logic        in_view;
      logic        neg_x;
      logic        neg_y;
   } root_type;

endpackage

// File: sv/vpp_root_step.sv
// One step of the two column-length square roots and, in the first steps,
// of the two |X|/W and |Y|/W restoring divisions. Depends on vpp_pkg.
module vpp_root_step #(
   parameter int STEP = 0
) (
   input  vpp_pkg::root_type cur,
   output vpp_pkg::root_type nxt
);

   localparam logic [63:0] TrialBit = 64'd1 << (vpp_pkg::ROOT_TOP - 2 * STEP);
   localparam bit          DoRatio  = (STEP < vpp_pkg::RATIO_STEPS);
   localparam bit          NoShift  = (STEP == 0);

   logic [63:0] trial0;
   logic [63:0] trial1;
   logic [64:0] den_ext;
   logic [64:0] rx_s;
   logic [64:0] ry_s;
   logic [16:0] qx_s;
   logic [16:0] qy_s;

   always_comb begin
      nxt     = cur;
      trial0  = cur.r0 + TrialBit;
      trial1  = cur.r1 + TrialBit;
      den_ext = {1'b0, cur.den};

      if (cur.v0 >= trial0) begin
         nxt.v0 = cur.v0 - trial0;
         nxt.r0 = (cur.r0 >> 1) + TrialBit;
      end else begin
         nxt.r0 = cur.r0 >> 1;
      end
      if (cur.v1 >= trial1) begin
         nxt.v1 = cur.v1 - trial1;
         nxt.r1 = (cur.r1 >> 1) + TrialBit;
      end else begin
         nxt.r1 = cur.r1 >> 1;
      end

      // first step takes the integer bit without a shift
      rx_s = NoShift ? cur.rem_x : {cur.rem_x[63:0], 1'b0};
      ry_s = NoShift ? cur.rem_y : {cur.rem_y[63:0], 1'b0};
      qx_s = NoShift ? cur.q_x : {cur.q_x[15:0], 1'b0};
      qy_s = NoShift ? cur.q_y : {cur.q_y[15:0], 1'b0};
      if (DoRatio) begin
         nxt.rem_x = rx_s;
         nxt.q_x   = qx_s;
         if (rx_s >= den_ext) begin
            nxt.rem_x = rx_s - den_ext;
            nxt.q_x   = qx_s | 17'd1;
         end
         nxt.rem_y = ry_s;
         nxt.q_y   = qy_s;
         if (ry_s >= den_ext) begin
            nxt.rem_y = ry_s - den_ext;
            nxt.q_y   = qy_s | 17'd1;
         end
      end
   end

endmodule

// File: sv/view_projection_point_project.sv
// Top level of the view projection point pipeline: matrix registers,
// clip transform, frustum test, root/ratio steps and screen scaling.
// Depends on vpp_pkg and vpp_root_step.
//
// Usage:
//   req_* carries one world point per transaction (x, y, z in Q24.8).
//   rsp_* returns one result per point: rsp_tuser is the in-view flag,
//   rsp_tdata holds screen_x and screen_y (Q16.16, saturated, zero when
//   the point is out of view). Results leave in input order.
//   csr_* writes one 64-bit matrix register per cycle; write only while
//   no point is in flight.
// Timing:
//   38 register stages. One point per cycle sustained while rsp_tready
//   stays high. Depth is set by the 32 one-bit square-root steps for the two
//   column lengths; the 17 division steps for |X|/W and |Y|/W run beside
//   the first of them.
// Reset: clears every stage valid and loads the identity matrix.
// Stall: each stage holds while its successor is full and blocked, so
//   bubbles close up and input is taken while a result waits on rsp.
module view_projection_point_project (
   input  logic         clock,
   input  logic         reset,
   // points
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,    // world_x[31:0], world_y[63:32], world_z[95:64]
   // results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,    // screen_x[31:0], screen_y[63:32]
   output logic [0:0]   rsp_tuser,    // in_view[0]
   // matrix registers
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wr_data
);

   localparam int RootBase = 3;
   localparam int NumStg   = RootBase + vpp_pkg::ROOT_STEPS + 3;
   localparam int StgM1    = RootBase + vpp_pkg::ROOT_STEPS;
   localparam int StgM2    = StgM1 + 1;
   localparam int StgOut   = StgM2 + 1;

   // ---------------- matrix registers ----------------
   logic [63:0] regs_ff [vpp_pkg::NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[vpp_pkg::REG_R0_C01] <= vpp_pkg::RST_R0_C01;
         regs_ff[vpp_pkg::REG_R0_C23] <= vpp_pkg::RST_R0_C23;
         regs_ff[vpp_pkg::REG_R1_C01] <= vpp_pkg::RST_R1_C01;
         regs_ff[vpp_pkg::REG_R1_C23] <= vpp_pkg::RST_R1_C23;
         regs_ff[vpp_pkg::REG_R2_C01] <= vpp_pkg::RST_R2_C01;
         regs_ff[vpp_pkg::REG_R2_C23] <= vpp_pkg::RST_R2_C23;
         regs_ff[vpp_pkg::REG_R3_C01] <= vpp_pkg::RST_R3_C01;
         regs_ff[vpp_pkg::REG_R3_C23] <= vpp_pkg::RST_R3_C23;
      end else if (csr_wr_en) begin
         regs_ff[csr_addr] <= csr_wr_data;
      end
   end

   // entry row r, column c: register 2r + c/2, odd column in the high half
   logic signed [31:0] ent [4][4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            ent[r][c] = regs_ff[r * 2 + c / 2][32 * (c % 2) +: 32];
         end
      end
   end

   // ---------------- stage valids and flow control ----------------
   logic [NumStg-1:0] vld_ff;
   logic [NumStg-1:0] vld_in;
   logic [NumStg-1:0] en;

   always_comb begin
      en[NumStg-1] = !vld_ff[NumStg-1] || rsp_tready;
      for (int k = NumStg - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in     = {vld_ff[NumStg-2:0], req_tvalid};
   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NumStg; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // ---------------- stage 0: products ----------------
   logic signed [31:0] pt [3];
   logic signed [63:0] prod_in [3][4];
   logic signed [63:0] prod_ff [3][4];
   logic        [63:0] sq_in [2][3];
   logic        [63:0] sq_ff [2][3];
   logic signed [31:0] tr_ff [4];

   assign pt[0] = req_tdata[31:0];
   assign pt[1] = req_tdata[63:32];
   assign pt[2] = req_tdata[95:64];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = pt[r] * ent[r][c];
         end
         for (int c = 0; c < 2; c++) begin
            sq_in[c][r] = 64'(ent[r][c]) * 64'(ent[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
         for (int c = 0; c < 4; c++) tr_ff[c] <= ent[3][c];
      end
   end

   // ---------------- stage 1: clip sums, squared lengths ----------------
   function automatic logic signed [63:0] quarter(input logic signed [63:0] p);
      logic signed [63:0] adj;
      adj = p + (p[63] ? 64'sd3 : 64'sd0);   // round toward zero
      return adj >>> 2;
   endfunction

   logic signed [63:0] clip_in [4];
   logic signed [63:0] clip_ff [4];
   logic        [63:0] len_in [2];
   logic        [63:0] len_ff [2];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         clip_in[c] = (64'(tr_ff[c]) <<< 6) + quarter(prod_ff[0][c])
                    + quarter(prod_ff[1][c]) + quarter(prod_ff[2][c]);
      end
      for (int c = 0; c < 2; c++) begin
         len_in[c] = sq_ff[c][0] + sq_ff[c][1] + sq_ff[c][2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         clip_ff <= clip_in;
         len_ff  <= len_in;
      end
   end

   // ---------------- stage 2: frustum test, step setup ----------------
   vpp_pkg::root_type s3_in;
   vpp_pkg::root_type s3_ff;
   logic signed [63:0] cx;
   logic signed [63:0] cy;
   logic signed [63:0] cz;
   logic signed [63:0] cw;
   logic signed [63:0] ncw;

   always_comb begin
      cx  = clip_ff[0];
      cy  = clip_ff[1];
      cz  = clip_ff[2];
      cw  = clip_ff[3];
      ncw = -cw;
      s3_in.v0      = len_ff[0];
      s3_in.r0      = '0;
      s3_in.v1      = len_ff[1];
      s3_in.r1      = '0;
      s3_in.neg_x   = cx[63];
      s3_in.neg_y   = cy[63];
      s3_in.rem_x   = {1'b0, (cx[63] ? 64'(-cx) : 64'(cx))};
      s3_in.rem_y   = {1'b0, (cy[63] ? 64'(-cy) : 64'(cy))};
      s3_in.den     = cw;
      s3_in.q_x     = '0;
      s3_in.q_y     = '0;
      s3_in.in_view = (cw > 64'sd0) && (cx >= ncw) && (cx <= cw) && (cy >= ncw)
                      && (cy <= cw) && (cz >= 64'sd0) && (cz <= cw);
   end

   always_ff @(posedge clock) begin
      if (en[2]) s3_ff <= s3_in;
   end

   // ---------------- root / ratio steps ----------------
   vpp_pkg::root_type root_src [vpp_pkg::ROOT_STEPS];
   vpp_pkg::root_type root_in  [vpp_pkg::ROOT_STEPS];
   vpp_pkg::root_type root_ff  [vpp_pkg::ROOT_STEPS];

   assign root_src[0] = s3_ff;

   for (genvar k = 0; k < vpp_pkg::ROOT_STEPS; k++) begin : g_root
      if (k > 0) begin : g_link
         assign root_src[k] = root_ff[k-1];
      end
      vpp_root_step #(.STEP(k)) u_step (
         .cur (root_src[k]),
         .nxt (root_in[k])
      );
      always_ff @(posedge clock) begin
         if (en[RootBase + k]) root_ff[k] <= root_in[k];
      end
   end

   // ---------------- scale multiply ----------------
   vpp_pkg::root_type rt_last;
   logic [48:0] px_ff;
   logic [48:0] py_ff;
   logic [42:0] mx_ff;
   logic [42:0] my_ff;
   logic [2:0]  fl1_ff;   // {in_view, neg_y, neg_x}
   logic [2:0]  fl2_ff;

   assign rt_last = root_ff[vpp_pkg::ROOT_STEPS-1];

   // screen X uses the column 1 length, screen Y the column 0 length
   always_ff @(posedge clock) begin
      if (en[StgM1]) begin
         px_ff  <= 49'(rt_last.q_x) * 49'(rt_last.r1[31:0]);
         py_ff  <= 49'(rt_last.q_y) * 49'(rt_last.r0[31:0]);
         fl1_ff <= {rt_last.in_view, rt_last.neg_y, rt_last.neg_x};
      end
   end

   always_ff @(posedge clock) begin
      if (en[StgM2]) begin
         mx_ff  <= 43'((59'(px_ff) * 59'(vpp_pkg::SCREEN_MULT)) >> 16);
         my_ff  <= 43'((59'(py_ff) * 59'(vpp_pkg::SCREEN_MULT)) >> 16);
         fl2_ff <= fl1_ff;
      end
   end

   // ---------------- sign, saturate, output register ----------------
   function automatic logic [31:0] sat(input logic [42:0] m, input logic neg);
      logic [42:0] nm;
      nm = -m;
      if (neg) begin
         return (m > 43'h0_8000_0000) ? 32'h8000_0000 : nm[31:0];
      end
      return (m > 43'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   logic [31:0] sx_ff;
   logic [31:0] sy_ff;
   logic        iv_ff;

   always_ff @(posedge clock) begin
      if (en[StgOut]) begin
         iv_ff <= fl2_ff[2];
         sx_ff <= fl2_ff[2] ? sat(mx_ff, fl2_ff[0]) : 32'd0;
         sy_ff <= fl2_ff[2] ? sat(my_ff, fl2_ff[1]) : 32'd0;
      end
   end

   assign rsp_tvalid = vld_ff[NumStg-1];
   assign rsp_tdata  = {sy_ff, sx_ff};
   assign rsp_tuser  = iv_ff;

   // ---------------- checks ----------------
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("rejected point with nonzero screen position");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input blocked without a blocked result");

   a_take_in: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted point missing from first stage");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for view_projection_point_project: directed points and
// matrices, then random ones, compared against an in-bench projection model.
// Depends on vpp_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [63:0]  csr_wr_data = '0;

   typedef struct packed {
      logic        in_view;
      logic [31:0] screen_x;
      logic [31:0] screen_y;
   } proj_type;

   // directed row: point, plus a typed expectation where it is obvious
   typedef struct {
      logic [31:0] wx, wy, wz;
      bit          known;
      proj_type    res;
   } point_row_type;

   logic [63:0] matrix [vpp_pkg::NUM_REGS];   // shadow copy of csr registers
   proj_type    pending_q [$];       // projections still owed by the block
   int          n_err = 0;
   int          send_idle_pct = 0;   // sender gap chance
   int          recv_stall_pct = 0;  // receiver stall chance
   bit          hold_rsp = 1'b0;     // long receiver hold-off

   view_projection_point_project uut (.*);

   always #5 clock = ~clock;

   initial begin
      #100ms;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------- projection model ----------------
   function automatic longint entry(int row, int col);
      logic [63:0] w;
      w = matrix[row*2 + col/2];
      return (col % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
   endfunction

   function automatic longint clip(longint px, longint py, longint pz, int col);
      longint acc;
      acc = entry(3, col) * 64;
      acc += (px * entry(0, col)) / 4;   // SV division truncates toward zero
      acc += (py * entry(1, col)) / 4;
      acc += (pz * entry(2, col)) / 4;
      return acc;
   endfunction

   function automatic logic [63:0] col_len(int col);
      logic [63:0] s, v, res, b;
      longint e;
      s = 0;
      for (int r = 0; r < 3; r++) begin
         e = entry(r, col);
         s += 64'(e * e);
      end
      v = s; res = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] screen(longint num, longint w, logic [63:0] scale);
      logic [63:0]  mag, q, m;
      logic [127:0] wide;
      bit neg;
      neg = num < 0;
      mag = neg ? -num : num;
      wide = {64'd0, mag} << 16;        // |num| can exceed 2^61, keep the full product
      q = 64'(wide / 128'(w));
      m = (q * scale * 64'd1000) >> 16;
      if (neg) return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
      return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
   endfunction

   function automatic proj_type project(logic [31:0] wx, logic [31:0] wy,
                                        logic [31:0] wz);
      longint px, py, pz, cx, cy, cz, cw;
      proj_type o;
      px = $signed(wx); py = $signed(wy); pz = $signed(wz);
      cx = clip(px, py, pz, 0);
      cy = clip(px, py, pz, 1);
      cz = clip(px, py, pz, 2);
      cw = clip(px, py, pz, 3);
      o = '0;
      if (cw <= 0) return o;
      if (cx < -cw || cx > cw || cy < -cw || cy > cw || cz < 0 || cz > cw) return o;
      o.in_view  = 1'b1;
      o.screen_x = screen(cx, cw, col_len(1));
      o.screen_y = screen(cy, cw, col_len(0));
      return o;
   endfunction

   // ---------------- checking ----------------
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      n_err++;
   endtask

   always @(posedge clock) begin
      proj_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            report("unexpected transaction", rsp_tdata[31:0], 0);
         end else begin
            w = pending_q.pop_front();
            if (rsp_tuser[0] !== w.in_view) report("in_view", rsp_tuser[0], w.in_view);
            if (rsp_tdata[31:0] !== w.screen_x) report("screen_x", rsp_tdata[31:0], w.screen_x);
            if (rsp_tdata[63:32] !== w.screen_y)
               report("screen_y", rsp_tdata[63:32], w.screen_y);
         end
      end
   end

   // receiver ready pattern
   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------- driving ----------------
   // valid stays up after an accept; drain() or an idle gap in the next call drops it
   task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                             bit known = 0, proj_type res = '0);
      proj_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      p = project(wx, wy, wz);
      if (known && p !== res) begin
         report("table row", p[31:0], res[31:0]);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wz, wy, wx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_q.push_back(p);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= val;
      matrix[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q16(int span);
      return 32'($signed($urandom_range(2 * span)) - span);
   endfunction

   // random matrix with entries within +-3.0 (Q16.16), or raw noise
   task automatic load_random_matrix(bit wild);
      for (int i = 0; i < vpp_pkg::NUM_REGS; i++) begin
         if (wild) write_reg(3'(i), {$urandom, $urandom});
         else write_reg(3'(i), {rand_q16(3 << 16), rand_q16(3 << 16)});
      end
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return rand_q16(256 * 4);
         2: return rand_q16(256 * 64);
         default: return rand_q16(64);
      endcase
   endfunction

   point_row_type point_table [] = '{
      '{32'd0, 32'd0, 32'd0, 1, '{1'b1, 32'd0, 32'd0}},            // origin, identity
      '{32'd256, 32'd0, 32'd0, 1, '{1'b1, 32'h03e8_0000, 32'd0}},  // x = +1 edge
      '{32'hffff_ff00, 32'd0, 32'd0, 1, '{1'b1, 32'hfc18_0000, 32'd0}},
      '{32'd0, 32'd256, 32'd256, 1, '{1'b1, 32'd0, 32'h03e8_0000}},
      '{32'd257, 32'd0, 32'd0, 1, '{1'b0, 32'd0, 32'd0}},          // just outside
      '{32'd0, 32'd0, 32'hffff_ffff, 1, '{1'b0, 32'd0, 32'd0}},    // z below zero
      '{32'd0, 32'd0, 32'd257, 1, '{1'b0, 32'd0, 32'd0}},          // z above one
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, '{1'b0, 32'd0, 32'd0}},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, '{1'b0, 32'd0, 32'd0}},
      '{32'd128, 32'hffff_ff80, 32'd128, 0, '0},
      '{32'h5555_5555, 32'haaaa_aaaa, 32'd77, 0, '0}
   };

   initial begin
      matrix = '{vpp_pkg::RST_R0_C01, vpp_pkg::RST_R0_C23,
                 vpp_pkg::RST_R1_C01, vpp_pkg::RST_R1_C23,
                 vpp_pkg::RST_R2_C01, vpp_pkg::RST_R2_C23,
                 vpp_pkg::RST_R3_C01, vpp_pkg::RST_R3_C23};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity matrix after reset
      foreach (point_table[i])
         send_point(point_table[i].wx, point_table[i].wy, point_table[i].wz,
                    point_table[i].known, point_table[i].res);
      drain();

      // directed: huge X and Y scale entries, then W negated (rejects)
      write_reg(vpp_pkg::REG_R0_C01, {32'h7fff_ffff, 32'h7fff_ffff});
      write_reg(vpp_pkg::REG_R1_C01, {32'h8000_0000, 32'h8000_0000});
      send_point(32'd256, 32'd0, 32'd0);
      send_point(32'hffff_ff00, 32'd0, 32'd0);
      send_point(32'd0, 32'd256, 32'd0);
      drain();
      write_reg(vpp_pkg::REG_R3_C23, {32'hffff_0000, 32'd0});   // W = -1
      send_point(32'd0, 32'd0, 32'd0);
      drain();
      write_reg(vpp_pkg::REG_R3_C23, 64'hffff_ffff_ffff_ffff);  // register extremes
      write_reg(vpp_pkg::REG_R2_C23, 64'd0);
      send_point(32'd10, 32'd20, 32'd30);
      drain();

      // random phases with varying idle/stall patterns
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         load_random_matrix(ph == 7);
         if (ph == 2) begin
            // long hold-off while points keep coming: pipeline backs up
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 110; n++)
            send_point(rand_coord(), rand_coord(), rand_coord());
         drain();   // sender pause until every result is back
      end

      repeat (60) @(posedge clock);
      if (n_err == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
sv/vpp_pkg.sv
sv/vpp_root_step.sv
sv/view_projection_point_project.sv
tb/tb_top.sv
